/* src/indexed_slot_array_deque_defines.svh */
// Assertion macros shared by the slot array deque RTL.
`ifndef INDEXED_SLOT_ARRAY_DEQUE_DEFINES_SVH
`define INDEXED_SLOT_ARRAY_DEQUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ISAD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot array deque check failed");

// Check that cons holds in the cycle after ante.
`define ISAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot array deque check failed");

`endif

/* src/isad_pkg.sv */
// Package with command, status and sequencer types for the slot array deque.
`default_nettype none

package isad_pkg;

    typedef enum logic [2:0] {
        CMD_SET     = 3'd0,
        CMD_UNSET   = 3'd1,
        CMD_GET     = 3'd2,
        CMD_APPEND  = 3'd3,
        CMD_DEQUEUE = 3'd4,
        CMD_POP     = 3'd5,
        CMD_NORM    = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NEGSET = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FIX,
        S_ADDR,
        S_MEM,
        S_RDWAIT,
        S_FINISH
    } state_t;

    localparam int INDEX_BITS = 16;
    localparam int DIV_STEPS  = INDEX_BITS;

endpackage

`default_nettype wire

/* src/indexed_slot_array_deque.sv */
// Top level of the slot array deque: sequencer, shared remainder unit and slot memory.
//
// Input channel: cmd, index, write_value with in_valid / in_stall. A word is taken
// when in_valid is high and in_stall is low. The block takes one command at a time
// and holds in_stall high until that command has its result staged.
// Output channel: status, read_value, result_index, length_now with out_valid /
// out_stall. The result waits in an output register while out_stall is high, and
// the next command may be taken meanwhile; it then holds in its final step until
// the output register frees.
// Sequence: unset, get and normalize run the index magnitude through one shared
// restoring remainder unit, one quotient bit a cycle over the 16 index bits, and a
// fix step; unset and get then take address, memory and read steps, normalize
// finishes. set and append take address and memory steps, dequeue and pop address,
// memory and read steps, errors and unused codes go straight to the final step.
// The next word is taken only after the result is staged. Dequeue moves a head
// pointer instead of shifting slots; the single memory port sets read-then-clear.
// Reset: the length and head pointer clear at once; the slot memory is then
// swept to zero, one slot a cycle, over all CAPACITY slots with in_stall high.
`default_nettype none
`include "indexed_slot_array_deque_defines.svh"

module indexed_slot_array_deque #(
    parameter int CAPACITY  = 256,
    parameter int WORD_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [2:0]                         cmd,
    input  wire logic signed [15:0]                 index,
    input  wire logic [WORD_BITS-1:0]               write_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output isad_pkg::status_t                       status,
    output logic [WORD_BITS-1:0]                    read_value,
    output logic [$clog2(CAPACITY)-1:0]             result_index,
    output logic [$clog2(CAPACITY+1)-1:0]           length_now
);
    import isad_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int CNT_W  = $clog2(DIV_STEPS);

    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic                 out_valid_reg, out_valid_next;

    cmd_t                 cmd_reg, cmd_next;
    logic                 neg_reg, neg_next;
    logic [INDEX_BITS-1:0] dvd_reg, dvd_next;
    logic [WORD_BITS-1:0] wv_reg, wv_next;
    status_t              st_reg, st_next;
    logic [WORD_BITS-1:0] val_reg, val_next;
    logic [ADDR_W-1:0]    log_reg, log_next;
    logic [ADDR_W-1:0]    phys_reg, phys_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    status_t              status_reg, status_next;
    logic [WORD_BITS-1:0] read_value_reg, read_value_next;
    logic [ADDR_W-1:0]    result_index_reg, result_index_next;
    logic [LEN_W-1:0]     length_now_reg, length_now_next;

    logic [LEN_W:0]       trial;
    logic [LEN_W-1:0]     fixed_rem;
    logic [ADDR_W:0]      phys_sum;

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign read_value   = read_value_reg;
    assign result_index = result_index_reg;
    assign length_now   = length_now_reg;

    assign trial     = {rem_reg, dvd_reg[INDEX_BITS-1]};
    assign fixed_rem = (neg_reg && (rem_reg != '0)) ? (len_reg - rem_reg) : rem_reg;
    assign phys_sum  = {1'b0, head_reg} + {1'b0, log_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            len_reg       <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            len_reg       <= len_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        neg_reg          <= neg_next;
        dvd_reg          <= dvd_next;
        wv_reg           <= wv_next;
        st_reg           <= st_next;
        val_reg          <= val_next;
        log_reg          <= log_next;
        phys_reg         <= phys_next;
        rem_reg          <= rem_next;
        cnt_reg          <= cnt_next;
        status_reg       <= status_next;
        read_value_reg   <= read_value_next;
        result_index_reg <= result_index_next;
        length_now_reg   <= length_now_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        len_next          = len_reg;
        head_next         = head_reg;
        out_valid_next    = out_valid_reg;
        cmd_next          = cmd_reg;
        neg_next          = neg_reg;
        dvd_next          = dvd_reg;
        wv_next           = wv_reg;
        st_next           = st_reg;
        val_next          = val_reg;
        log_next          = log_reg;
        phys_next         = phys_reg;
        rem_next          = rem_reg;
        cnt_next          = cnt_reg;
        status_next       = status_reg;
        read_value_next   = read_value_reg;
        result_index_next = result_index_reg;
        length_now_next   = length_now_reg;
        mem_we            = 1'b0;
        mem_addr          = phys_reg;
        mem_wdata         = '0;

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd_t'(cmd);
                    neg_next = index[INDEX_BITS-1];
                    dvd_next = index[INDEX_BITS-1] ? (~$unsigned(index) + 1'b1)
                                                   : $unsigned(index);
                    wv_next  = write_value;
                    st_next  = ST_OK;
                    val_next = '0;
                    log_next = '0;
                    rem_next = '0;
                    cnt_next = '0;
                    case (cmd_t'(cmd))
                        CMD_SET:
                        begin
                            if (index[INDEX_BITS-1])
                            begin
                                st_next    = ST_NEGSET;
                                state_next = S_FINISH;
                            end
                            else if (32'($unsigned(index)) >= 32'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                log_next   = ADDR_W'($unsigned(index));
                                state_next = S_ADDR;
                            end
                        end
                        CMD_UNSET, CMD_GET, CMD_NORM:
                        begin
                            if (len_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (len_reg >= LEN_W'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                log_next   = ADDR_W'(len_reg);
                                state_next = S_ADDR;
                            end
                        end
                        CMD_DEQUEUE, CMD_POP:
                        begin
                            if (len_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                log_next   = (cmd_t'(cmd) == CMD_POP)
                                             ? ADDR_W'(len_reg - LEN_W'(1)) : '0;
                                state_next = S_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                // restoring remainder step, one dividend bit per cycle
                if (trial >= {1'b0, len_reg})
                begin
                    rem_next = LEN_W'(trial - {1'b0, len_reg});
                end
                else
                begin
                    rem_next = LEN_W'(trial);
                end
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIX;
                end
            end

            S_FIX:
            begin
                log_next   = ADDR_W'(fixed_rem);
                state_next = (cmd_reg == CMD_NORM) ? S_FINISH : S_ADDR;
            end

            S_ADDR:
            begin
                if (phys_sum >= (ADDR_W+1)'(CAPACITY))
                begin
                    phys_next = ADDR_W'(phys_sum - (ADDR_W+1)'(CAPACITY));
                end
                else
                begin
                    phys_next = ADDR_W'(phys_sum);
                end
                state_next = S_MEM;
            end

            S_MEM:
            begin
                case (cmd_reg)
                    CMD_SET:
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = wv_reg;
                        if (len_reg < (LEN_W'(log_reg) + LEN_W'(1)))
                        begin
                            len_next = LEN_W'(log_reg) + LEN_W'(1);
                        end
                        state_next = S_FINISH;
                    end
                    CMD_APPEND:
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = wv_reg;
                        len_next   = len_reg + LEN_W'(1);
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_RDWAIT;
                    end
                endcase
            end

            S_RDWAIT:
            begin
                val_next = rdata_reg;
                case (cmd_reg)
                    CMD_UNSET:
                    begin
                        mem_we = 1'b1;
                        if (LEN_W'(log_reg) == (len_reg - LEN_W'(1)))
                        begin
                            len_next = len_reg - LEN_W'(1);
                        end
                    end
                    CMD_DEQUEUE:
                    begin
                        mem_we    = 1'b1;
                        len_next  = len_reg - LEN_W'(1);
                        head_next = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0
                                                                        : head_reg + 1'b1;
                    end
                    CMD_POP:
                    begin
                        mem_we   = 1'b1;
                        len_next = len_reg - LEN_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // hold until the output register frees
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = st_reg;
                    read_value_next = val_reg;
                    if ((st_reg == ST_OK) && ((cmd_reg == CMD_APPEND) || (cmd_reg == CMD_NORM)))
                    begin
                        result_index_next = log_reg;
                    end
                    else
                    begin
                        result_index_next = '0;
                    end
                    length_now_next = len_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ISAD_ASSERT_SAME(a_len_in_range, clk, rst_n, 1'b1, len_reg <= LEN_W'(CAPACITY))
    `ISAD_ASSERT_SAME(a_head_in_range, clk, rst_n, 1'b1, {1'b0, head_reg} < (ADDR_W+1)'(CAPACITY))
    `ISAD_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, state_reg != S_IDLE)
    `ISAD_ASSERT_NEXT(a_finish_holds, clk, rst_n, (state_reg == S_FINISH) && out_valid_reg && out_stall, (state_reg == S_FINISH) && out_valid_reg)

endmodule

`default_nettype wire
